// File: hdl/erbe_pkg.sv
// Shared widths, constants, payload types and the entropy row table
// for the error rate / binary entropy estimator. No dependencies.
`default_nettype none

package erbe_pkg;

   localparam int unsigned COUNT_BITS_DEF = 32;
   localparam int unsigned PORT_CNT_W     = 32;
   localparam int unsigned RATE_W         = 18;
   localparam int unsigned THR_W          = 14;
   localparam int unsigned ROW_W          = 17;
   localparam int unsigned DELTA_W        = 14;
   localparam int unsigned BASE_W         = 11;
   localparam int unsigned IDX_W          = 4;
   localparam int unsigned PROD_W         = 24;
   localparam int unsigned PRE_SHIFT      = 5;
   localparam int unsigned X_W            = PROD_W - PRE_SHIFT;
   localparam int unsigned RECIP_W        = 20;
   localparam int unsigned RECIP_SHIFT    = 25;
   localparam int unsigned MX_W           = X_W + RECIP_W;
   localparam int unsigned ROWS           = 12;
   localparam int unsigned ROW_STEP       = 1440;

   localparam logic [RATE_W-1:0]  DENOM     = 18'd144000;
   localparam logic [THR_W-1:0]   THR_RESET = 14'd15840;
   localparam logic [ROW_W-1:0]   ENT_LAST  = 17'd71988;
   // ceil(2^25 / 45): exact floor division by 45 for operands below 2^19
   localparam logic [RECIP_W-1:0] RECIP     = 20'd745655;

   typedef struct packed {
      logic no_samples;
      logic saturate;
      logic in_limit;
   } flag_type;

   typedef struct packed {
      logic [RATE_W-1:0] rate;
      flag_type          flags;
   } rate_item_type;

   typedef struct packed {
      logic [RATE_W-1:0] rate_numerator;
      logic [RATE_W-1:0] entropy_numerator;
      logic              channel_ok;
      logic              no_samples;
   } rsp_item_type;

   function automatic int unsigned cnt_width(int unsigned bits);
      return (bits < PORT_CNT_W) ? bits : PORT_CNT_W;
   endfunction

   function automatic logic [ROW_W-1:0] ent_row(logic [IDX_W-1:0] idx);
      logic [ROW_W-1:0] v;
      unique case (idx)
         4'd0:    v = 17'd0;
         4'd1:    v = 17'd11634;
         4'd2:    v = 17'd20367;
         4'd3:    v = 17'd27992;
         4'd4:    v = 17'd34890;
         4'd5:    v = 17'd41241;
         4'd6:    v = 17'd47152;
         4'd7:    v = 17'd52693;
         4'd8:    v = 17'd57914;
         4'd9:    v = 17'd62852;
         4'd10:   v = 17'd67535;
         4'd11:   v = 17'd71988;
         default: v = 17'd0;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

// File: hdl/erbe_if.sv
// Valid/ready channel interfaces: count request, result response and
// threshold write. Depends on erbe_pkg.
`default_nettype none

interface erbe_req_if;
   import erbe_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [PORT_CNT_W-1:0] error_count;
   logic [PORT_CNT_W-1:0] sample_count;
   modport source (output valid, output error_count, output sample_count, input ready);
   modport sink   (input valid, input error_count, input sample_count, output ready);
endinterface

interface erbe_rsp_if;
   import erbe_pkg::*;
   logic              valid;
   logic              ready;
   logic [RATE_W-1:0] rate_numerator;
   logic [RATE_W-1:0] entropy_numerator;
   logic              channel_ok;
   logic              no_samples;
   modport source (output valid, output rate_numerator, output entropy_numerator,
                   output channel_ok, output no_samples, input ready);
   modport sink   (input valid, input rate_numerator, input entropy_numerator,
                   input channel_ok, input no_samples, output ready);
endinterface

interface erbe_csr_if;
   import erbe_pkg::*;
   logic             valid;
   logic             ready;
   logic [THR_W-1:0] abort_threshold;
   modport source (output valid, output abort_threshold, input ready);
   modport sink   (input valid, input abort_threshold, output ready);
endinterface

`default_nettype wire

// File: hdl/error_rate_binary_entropy_estimator_top.sv
// Top level of the error rate / binary entropy estimator.
// Depends on erbe_pkg, erbe_if, erbe_front, erbe_div and erbe_entropy.
`default_nettype none

// Each request transaction carries an error count and a sample count and
// yields one response transaction: the error rate over 144000 (floor,
// saturated at 144000), the interpolated binary entropy over 144000, the
// channel accept flag and the zero-sample flag. The block takes one
// request per cycle unless backpressure stalls it and returns results in
// order through two front-end stages (scaling multiply, threshold product
// and compare), 18 divider stages that each resolve one quotient bit, and
// four entropy stages (row select, slope multiply, reciprocal multiply,
// final select). Backpressure on the response side stalls only the stages
// that are full, so empty stages keep accepting. The threshold register
// resets to 15840, is always ready for a write, and is to be written only
// while no transaction is in flight.
module error_rate_binary_entropy_estimator_top #(
   parameter int unsigned COUNT_BITS = erbe_pkg::COUNT_BITS_DEF
) (
   input wire logic clock,
   input wire logic reset,
   erbe_req_if.sink   req_if,
   erbe_rsp_if.source rsp_if,
   erbe_csr_if.sink   csr_if
);
   import erbe_pkg::*;

   localparam int unsigned CNT_W = cnt_width(COUNT_BITS);

   logic [THR_W-1:0]  thr_ff;

   logic              fd_valid;
   logic              fd_ready;
   logic [CNT_W-1:0]  fd_rem;
   logic [RATE_W-1:0] fd_low;
   logic [CNT_W-1:0]  fd_dvs;
   flag_type          fd_flags;

   logic              de_valid;
   logic              de_ready;
   rate_item_type     de_item;

   rsp_item_type      rsp_item;

   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_RESET;
      end else if (csr_if.valid) begin
         thr_ff <= csr_if.abort_threshold;
      end
   end

   erbe_front #(
      .COUNT_BITS (COUNT_BITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_if.valid),
      .in_ready     (req_if.ready),
      .error_count  (req_if.error_count),
      .sample_count (req_if.sample_count),
      .threshold    (thr_ff),
      .out_valid    (fd_valid),
      .out_ready    (fd_ready),
      .out_rem      (fd_rem),
      .out_low      (fd_low),
      .out_dvs      (fd_dvs),
      .out_flags    (fd_flags)
   );

   erbe_div #(
      .COUNT_BITS (COUNT_BITS)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fd_valid),
      .in_ready  (fd_ready),
      .in_rem    (fd_rem),
      .in_low    (fd_low),
      .in_dvs    (fd_dvs),
      .in_flags  (fd_flags),
      .out_valid (de_valid),
      .out_ready (de_ready),
      .out_item  (de_item)
   );

   erbe_entropy u_entropy (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (de_valid),
      .in_ready  (de_ready),
      .in_item   (de_item),
      .threshold (thr_ff),
      .out_valid (rsp_if.valid),
      .out_ready (rsp_if.ready),
      .out_item  (rsp_item)
   );

   assign rsp_if.rate_numerator    = rsp_item.rate_numerator;
   assign rsp_if.entropy_numerator = rsp_item.entropy_numerator;
   assign rsp_if.channel_ok        = rsp_item.channel_ok;
   assign rsp_if.no_samples        = rsp_item.no_samples;

endmodule

`default_nettype wire

// File: hdl/erbe_front.sv
// Front end: count masking, scaling by 144000, threshold product and the
// accept compare, two stages. Depends on erbe_pkg.
`default_nettype none

module erbe_front #(
   parameter  int unsigned COUNT_BITS = 32,
   localparam int unsigned CNT_W      = erbe_pkg::cnt_width(COUNT_BITS)
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            in_valid,
   output      logic                            in_ready,
   input  wire logic [erbe_pkg::PORT_CNT_W-1:0] error_count,
   input  wire logic [erbe_pkg::PORT_CNT_W-1:0] sample_count,
   input  wire logic [erbe_pkg::THR_W-1:0]      threshold,
   output      logic                            out_valid,
   input  wire logic                            out_ready,
   output      logic [CNT_W-1:0]                out_rem,
   output      logic [erbe_pkg::RATE_W-1:0]     out_low,
   output      logic [CNT_W-1:0]                out_dvs,
   output      erbe_pkg::flag_type              out_flags
);
   import erbe_pkg::*;

   localparam int unsigned SC_W = CNT_W + RATE_W;
   localparam int unsigned TP_W = CNT_W + THR_W;

   logic [CNT_W-1:0] errs;
   logic [CNT_W-1:0] samp;
   logic             en_a;
   logic             en_b;

   logic             va_ff;
   logic [SC_W-1:0]  scaled_ff, scaled_in;
   logic [TP_W-1:0]  tprod_ff, tprod_in;
   logic [CNT_W-1:0] samp_ff;
   logic             nos_ff;
   logic             sat_ff;

   logic             vb_ff;
   logic [CNT_W-1:0] rem_ff;
   logic [RATE_W-1:0] low_ff;
   logic [CNT_W-1:0] dvs_ff;
   flag_type         flg_ff, flg_in;

   assign errs = error_count[CNT_W-1:0];
   assign samp = sample_count[CNT_W-1:0];

   assign en_b     = !vb_ff || out_ready;
   assign en_a     = !va_ff || en_b;
   assign in_ready = en_a;

   assign scaled_in = SC_W'(errs) * SC_W'(DENOM);
   assign tprod_in  = TP_W'(samp) * TP_W'(threshold);

   always_comb begin
      flg_in.no_samples = nos_ff;
      flg_in.saturate   = sat_ff;
      flg_in.in_limit   = scaled_ff <= SC_W'(tprod_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
      end else begin
         if (en_a) va_ff <= in_valid;
         if (en_b) vb_ff <= va_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en_a) begin
         scaled_ff <= scaled_in;
         tprod_ff  <= tprod_in;
         samp_ff   <= samp;
         nos_ff    <= (samp == '0);
         sat_ff    <= (errs >= samp);
      end
      if (en_b) begin
         rem_ff <= scaled_ff[SC_W-1:RATE_W];
         low_ff <= scaled_ff[RATE_W-1:0];
         dvs_ff <= samp_ff;
         flg_ff <= flg_in;
      end
   end

   assign out_valid = vb_ff;
   assign out_rem   = rem_ff;
   assign out_low   = low_ff;
   assign out_dvs   = dvs_ff;
   assign out_flags = flg_ff;

endmodule

`default_nettype wire

// File: hdl/erbe_div.sv
// Restoring divider, one quotient bit per pipeline stage, 18 stages.
// Quotient bits shift in as dividend bits shift out. Depends on erbe_pkg.
`default_nettype none

module erbe_div #(
   parameter  int unsigned COUNT_BITS = 32,
   localparam int unsigned CNT_W      = erbe_pkg::cnt_width(COUNT_BITS)
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        in_valid,
   output      logic                        in_ready,
   input  wire logic [CNT_W-1:0]            in_rem,
   input  wire logic [erbe_pkg::RATE_W-1:0] in_low,
   input  wire logic [CNT_W-1:0]            in_dvs,
   input  wire erbe_pkg::flag_type          in_flags,
   output      logic                        out_valid,
   input  wire logic                        out_ready,
   output      erbe_pkg::rate_item_type     out_item
);
   import erbe_pkg::*;

   localparam int unsigned NS = RATE_W;

   logic [NS-1:0]     v_ff;
   logic [NS-1:0]     en;
   logic [RATE_W-1:0] z_ff   [NS];
   flag_type          flg_ff [NS];
   logic [CNT_W-1:0]  rem_ff [NS-1];
   logic [CNT_W-1:0]  dvs_ff [NS-1];

   always_comb begin
      en[NS-1] = !v_ff[NS-1] || out_ready;
      for (int i = NS - 2; i >= 0; i--) begin
         en[i] = !v_ff[i] || en[i+1];
      end
   end

   assign in_ready = en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[0]) v_ff[0] <= in_valid;
         for (int i = 1; i < NS; i++) begin
            if (en[i]) v_ff[i] <= v_ff[i-1];
         end
      end
   end

   for (genvar i = 0; i < NS; i++) begin : g_stage
      logic [CNT_W-1:0]  src_rem;
      logic [CNT_W-1:0]  src_dvs;
      logic [RATE_W-1:0] src_z;
      flag_type          src_flg;
      logic [CNT_W:0]    trial;
      logic              take;

      if (i == 0) begin : g_head
         assign src_rem = in_rem;
         assign src_dvs = in_dvs;
         assign src_z   = in_low;
         assign src_flg = in_flags;
      end else begin : g_body
         assign src_rem = rem_ff[i-1];
         assign src_dvs = dvs_ff[i-1];
         assign src_z   = z_ff[i-1];
         assign src_flg = flg_ff[i-1];
      end

      assign trial = {src_rem, src_z[RATE_W-1]};
      assign take  = trial >= {1'b0, src_dvs};

      always_ff @(posedge clock) begin
         if (en[i]) begin
            z_ff[i]   <= {src_z[RATE_W-2:0], take};
            flg_ff[i] <= src_flg;
         end
      end

      if (i < NS - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (en[i]) begin
               rem_ff[i] <= take ? CNT_W'(trial - {1'b0, src_dvs}) : trial[CNT_W-1:0];
               dvs_ff[i] <= src_dvs;
            end
         end
      end
   end

   assign out_valid      = v_ff[NS-1];
   assign out_item.rate  = z_ff[NS-1];
   assign out_item.flags = flg_ff[NS-1];

endmodule

`default_nettype wire

// File: hdl/erbe_entropy.sv
// Entropy interpolation, four stages: row select, slope product,
// reciprocal scaling by 1/1440, final select. Depends on erbe_pkg.
`default_nettype none

module erbe_entropy (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   in_valid,
   output      logic                   in_ready,
   input  wire erbe_pkg::rate_item_type in_item,
   input  wire logic [erbe_pkg::THR_W-1:0] threshold,
   output      logic                   out_valid,
   input  wire logic                   out_ready,
   output      erbe_pkg::rsp_item_type out_item
);
   import erbe_pkg::*;

   typedef enum logic [1:0] {
      SEL_ZERO,
      SEL_FULL,
      SEL_LAST,
      SEL_INTERP
   } sel_type;

   typedef struct packed {
      sel_type           sel;
      logic [RATE_W-1:0] rate;
      logic              ok;
      logic              nos;
      logic [ROW_W-1:0]  rowv;
   } common_type;

   logic en1, en2, en3, en4;
   logic v1_ff, v2_ff, v3_ff, v4_ff;

   logic [RATE_W-1:0]  rate_f;
   logic [IDX_W-1:0]   idx;
   logic [THR_W-1:0]   start;
   common_type         c1_in;
   logic [DELTA_W-1:0] delta_in;
   logic [BASE_W-1:0]  base_in;

   common_type         c1_ff, c2_ff, c3_ff;
   logic [DELTA_W-1:0] delta_ff;
   logic [BASE_W-1:0]  base_ff;
   logic [PROD_W-1:0]  prod_ff;
   logic [MX_W-1:0]    mx_ff;
   logic [DELTA_W-1:0] frac;
   rsp_item_type       out_ff, out_in;

   assign en4      = !v4_ff || out_ready;
   assign en3      = !v3_ff || en4;
   assign en2      = !v2_ff || en3;
   assign en1      = !v1_ff || en2;
   assign in_ready = en1;

   always_comb begin
      if (in_item.flags.no_samples) begin
         rate_f = '0;
      end else if (in_item.flags.saturate) begin
         rate_f = DENOM;
      end else begin
         rate_f = in_item.rate;
      end

      idx = '0;
      for (int k = 1; k < ROWS; k++) begin
         if (rate_f >= RATE_W'(k * ROW_STEP)) idx = idx + 1'b1;
      end

      start    = THR_W'(idx * ROW_STEP);
      base_in  = BASE_W'(rate_f[THR_W-1:0] - start);
      delta_in = DELTA_W'(ent_row(idx + 1'b1) - ent_row(idx));

      c1_in.rate = rate_f;
      c1_in.ok   = !in_item.flags.no_samples && in_item.flags.in_limit;
      c1_in.nos  = in_item.flags.no_samples;
      c1_in.rowv = ent_row(idx);
      priority if (rate_f == '0) begin
         c1_in.sel = SEL_ZERO;
      end else if (rate_f >= RATE_W'(threshold)) begin
         c1_in.sel = SEL_FULL;
      end else if (idx >= IDX_W'(ROWS - 1)) begin
         c1_in.sel = SEL_LAST;
      end else begin
         c1_in.sel = SEL_INTERP;
      end
   end

   assign frac = mx_ff[RECIP_SHIFT+DELTA_W-1:RECIP_SHIFT];

   always_comb begin
      out_in.rate_numerator = c3_ff.rate;
      out_in.channel_ok     = c3_ff.ok;
      out_in.no_samples     = c3_ff.nos;
      unique case (c3_ff.sel)
         SEL_ZERO:   out_in.entropy_numerator = '0;
         SEL_FULL:   out_in.entropy_numerator = DENOM;
         SEL_LAST:   out_in.entropy_numerator = RATE_W'(ENT_LAST);
         SEL_INTERP: out_in.entropy_numerator = RATE_W'(c3_ff.rowv) + RATE_W'(frac);
         default:    out_in.entropy_numerator = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= in_valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         c1_ff    <= c1_in;
         delta_ff <= delta_in;
         base_ff  <= base_in;
      end
      if (en2) begin
         c2_ff   <= c1_ff;
         prod_ff <= PROD_W'(delta_ff) * PROD_W'(base_ff);
      end
      if (en3) begin
         c3_ff <= c2_ff;
         // floor(p / 1440) = floor((p >> 5) / 45)
         mx_ff <= MX_W'(prod_ff[PROD_W-1:PRE_SHIFT]) * MX_W'(RECIP);
      end
      if (en4) begin
         out_ff <= out_in;
      end
   end

   assign out_valid = v4_ff;
   assign out_item  = out_ff;

endmodule

`default_nettype wire

// File: tb/sv/tb_error_rate_binary_entropy_estimator_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for error_rate_binary_entropy_estimator_top.
// Drives count-pair transactions, predicts rate/entropy/flags and checks
// every response in order. Depends on erbe_pkg, erbe_if and the RTL.

module tb_error_rate_binary_entropy_estimator_top;
   import erbe_pkg::*;

   localparam int unsigned CLK_HALF     = 6;
   localparam int unsigned DRAIN_CYCLES = 32;
   localparam int unsigned HOLD_CYCLES  = 300;
   localparam int unsigned MAX_PRINTS   = 50;
   localparam logic [THR_W-1:0] THR_MAX = '1;
   localparam logic [THR_W-1:0] THR_MIN = '0;

   logic clock;
   logic reset;

   erbe_req_if req_bus ();
   erbe_rsp_if rsp_bus ();
   erbe_csr_if csr_bus ();

   error_rate_binary_entropy_estimator_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus),
      .csr_if (csr_bus)
   );

   rsp_item_type     expected_results [$];
   logic [THR_W-1:0] abort_thr;
   int unsigned      idle_pct;
   int unsigned      stall_pct;
   int unsigned      hold_len;
   int unsigned      hold_left;
   int unsigned      mismatch_count;
   int unsigned      requests_sent;
   int unsigned      results_checked;
   int unsigned      accepted_seen;
   int unsigned      zero_sample_seen;
   int unsigned      saturated_seen;
   int unsigned      thr_settings;

   initial begin
      clock = 1'b0;
      forever #(CLK_HALF) clock = ~clock;
   end

   initial begin
      #(2_000_000);
      $display("timeout: %0d transactions still outstanding", expected_results.size());
      $display("TEST FAILED");
      $finish;
   end

   // ---------------------------------------------------------------- predictor
   function automatic logic [63:0] entropy_row(logic [63:0] idx);
      case (idx)
         0:       return 64'd0;
         1:       return 64'd11634;
         2:       return 64'd20367;
         3:       return 64'd27992;
         4:       return 64'd34890;
         5:       return 64'd41241;
         6:       return 64'd47152;
         7:       return 64'd52693;
         8:       return 64'd57914;
         9:       return 64'd62852;
         10:      return 64'd67535;
         default: return 64'd71988;
      endcase
   endfunction

   function automatic rsp_item_type predict_estimate(logic [PORT_CNT_W-1:0] errs,
                                                     logic [PORT_CNT_W-1:0] samp,
                                                     logic [THR_W-1:0] thr);
      rsp_item_type res;
      logic [63:0]  scaled;
      logic [63:0]  rate;
      logic [63:0]  ent;
      logic [63:0]  idx;
      logic [63:0]  base;
      res = '0;
      if (samp == '0) begin
         res.no_samples = 1'b1;
      end else begin
         scaled = 64'(errs) * 64'(DENOM);
         if (errs >= samp) begin
            rate = 64'(DENOM);
         end else begin
            rate = scaled / 64'(samp);
            if (rate > 64'(DENOM)) rate = 64'(DENOM);
         end
         res.channel_ok = (scaled <= 64'(thr) * 64'(samp));
         if (rate == '0) begin
            ent = '0;
         end else if (rate >= 64'(thr)) begin
            ent = 64'(DENOM);
         end else begin
            idx = rate / 64'(ROW_STEP);
            if (idx >= 64'(ROWS - 1)) begin
               ent = entropy_row(64'(ROWS - 1));
            end else begin
               base = rate - idx * 64'(ROW_STEP);
               ent  = entropy_row(idx) +
                      ((entropy_row(idx + 64'd1) - entropy_row(idx)) * base) /
                      64'(ROW_STEP);
            end
         end
         res.rate_numerator    = rate[RATE_W-1:0];
         res.entropy_numerator = ent[RATE_W-1:0];
      end
      return res;
   endfunction

   // ---------------------------------------------------------------- checking
   task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
      mismatch_count++;
      if (mismatch_count <= MAX_PRINTS)
         $display("%0t ns: mismatch on %s after %0d responses: got %0d, want %0d",
                  $time, what, results_checked, got, want);
   endtask

   always @(posedge clock) begin : check_responses
      rsp_item_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_results.size() == 0) begin
            report_mismatch("unexpected response", 64'd1, 64'd0);
         end else begin
            want = expected_results.pop_front();
            if (rsp_bus.rate_numerator !== want.rate_numerator)
               report_mismatch("rate_numerator", 64'(rsp_bus.rate_numerator),
                               64'(want.rate_numerator));
            if (rsp_bus.entropy_numerator !== want.entropy_numerator)
               report_mismatch("entropy_numerator", 64'(rsp_bus.entropy_numerator),
                               64'(want.entropy_numerator));
            if (rsp_bus.channel_ok !== want.channel_ok)
               report_mismatch("channel_ok", 64'(rsp_bus.channel_ok), 64'(want.channel_ok));
            if (rsp_bus.no_samples !== want.no_samples)
               report_mismatch("no_samples", 64'(rsp_bus.no_samples), 64'(want.no_samples));
            results_checked++;
            accepted_seen    += 32'(want.channel_ok);
            zero_sample_seen += 32'(want.no_samples);
            if (want.rate_numerator == DENOM) saturated_seen++;
         end
      end
   end

   // ---------------------------------------------------------------- response side
   always @(posedge clock) begin
      if (hold_len != 0) begin
         hold_left <= hold_len;
         hold_len = 0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   always @(negedge clock) begin
      if (hold_left != 0)
         rsp_bus.ready <= 1'b0;
      else
         rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
   end

   // ---------------------------------------------------------------- request side
   task automatic send_counts(logic [PORT_CNT_W-1:0] errs, logic [PORT_CNT_W-1:0] samp);
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.error_count  <= errs;
      req_bus.sample_count <= samp;
      do @(posedge clock); while (!req_bus.ready);
      expected_results.push_back(predict_estimate(errs, samp, abort_thr));
      requests_sent++;
   endtask

   task automatic wait_for_drain();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_threshold(logic [THR_W-1:0] value);
      wait_for_drain();
      @(negedge clock);
      csr_bus.valid           <= 1'b1;
      csr_bus.abort_threshold <= value;
      do @(posedge clock); while (!csr_bus.ready);
      abort_thr = value;
      thr_settings++;
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic set_traffic(int unsigned idle, int unsigned stall);
      idle_pct  = idle;
      stall_pct = stall;
   endtask

   // Mix of full-range noise, rates aimed below, above and at the threshold,
   // small counts, zero counts and saturating counts.
   task automatic send_random_counts();
      logic [PORT_CNT_W-1:0] errs;
      logic [PORT_CNT_W-1:0] samp;
      logic [63:0]           scaled;
      int unsigned           target;
      case ($urandom_range(9))
         0: begin
            errs = $urandom;
            samp = $urandom;
         end
         1, 2, 3, 4, 5: begin
            samp = $urandom >> $urandom_range(31, 0);
            if (samp == 0) samp = 1;
            target = $urandom_range(int'(abort_thr) + 1500, 0);
            scaled = (64'(samp) * 64'(target)) / 64'(DENOM);
            errs   = scaled[PORT_CNT_W-1:0] + $urandom_range(1);
         end
         6: begin
            samp = $urandom >> $urandom_range(31, 0);
            if (samp == 0) samp = 1;
            scaled = (64'(samp) * 64'(abort_thr)) / 64'(DENOM);
            errs   = scaled[PORT_CNT_W-1:0] + $urandom_range(1);
         end
         7: begin
            samp = $urandom_range(255, 1);
            errs = $urandom_range(samp, 0);
         end
         8: begin
            if ($urandom_range(1)) begin
               errs = $urandom;
               samp = '0;
            end else begin
               errs = '0;
               samp = $urandom;
            end
         end
         default: begin
            samp = $urandom >> $urandom_range(31, 0);
            errs = samp | ($urandom >> $urandom_range(31, 0));
         end
      endcase
      send_counts(errs, samp);
   endtask

   // ---------------------------------------------------------------- tests
   task automatic test_directed_corners();
      set_traffic(0, 0);
      send_counts(32'd0, 32'd0);
      send_counts(32'hFFFF_FFFF, 32'd0);
      send_counts(32'd0, 32'hFFFF_FFFF);
      send_counts(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_counts(32'd1, 32'hFFFF_FFFF);
      send_counts(32'd5, 32'd1);
      send_counts(32'd1, 32'd1);
      send_counts(32'd1, 32'd100);
      send_counts(32'd11, 32'd100);
      send_counts(32'd10999, 32'd100000);
      send_counts(32'd11001, 32'd100000);
      send_counts(32'd1, 32'd2);
      send_counts(32'h7FFF_FFFF, 32'hFFFF_FFFF);
      send_counts(32'd3, 32'd1000);
      write_threshold(THR_MIN);
      send_counts(32'd0, 32'd7);
      send_counts(32'd1, 32'hFFFF_FFFF);
      send_counts(32'd1, 32'd1000);
      write_threshold(THR_MAX);
      send_counts(32'd1, 32'd9);
      send_counts(32'd16383, 32'd144000);
      send_counts(32'd1, 32'd8);
      send_counts(32'd11, 32'd100);
      write_threshold(14'd1);
      send_counts(32'd1, 32'd144000);
      send_counts(32'd1, 32'd144001);
      write_threshold(THR_RESET);
   endtask

   task automatic test_threshold_sweep();
      logic [THR_W-1:0] settings [7];
      settings = '{THR_MIN, 14'd1, 14'd1439, 14'd7777, 14'd14400, THR_RESET, THR_MAX};
      set_traffic(35, 35);
      foreach (settings[i]) begin
         write_threshold(settings[i]);
         repeat (12) send_random_counts();
      end
   endtask

   task automatic test_random_traffic();
      int unsigned idle_set  [4];
      int unsigned stall_set [4];
      idle_set  = '{0, 70, 0, 35};
      stall_set = '{0, 0, 70, 35};
      for (int p = 0; p < 4; p++) begin
         case (p)
            0:       write_threshold(THR_RESET);
            1:       write_threshold(THR_W'($urandom_range(15840, 1)));
            2:       write_threshold(14'd1);
            default: write_threshold(THR_MAX);
         endcase
         set_traffic(idle_set[p], stall_set[p]);
         repeat (115) send_random_counts();
      end
   endtask

   task automatic test_backpressure();
      write_threshold(THR_W'($urandom_range(15840, 1)));
      set_traffic(0, 0);
      @(negedge clock);
      hold_len = HOLD_CYCLES;
      repeat (80) send_random_counts();
   endtask

   initial begin
      reset                   = 1'b1;
      req_bus.valid           = 1'b0;
      req_bus.error_count     = '0;
      req_bus.sample_count    = '0;
      rsp_bus.ready           = 1'b0;
      csr_bus.valid           = 1'b0;
      csr_bus.abort_threshold = '0;
      abort_thr               = THR_RESET;
      idle_pct                = 0;
      stall_pct               = 0;
      hold_len                = 0;
      hold_left               = 0;
      mismatch_count          = 0;
      requests_sent           = 0;
      results_checked         = 0;
      accepted_seen           = 0;
      zero_sample_seen        = 0;
      saturated_seen          = 0;
      thr_settings            = 1;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed_corners();
      test_threshold_sweep();
      test_random_traffic();
      test_backpressure();
      wait_for_drain();

      $display("covered %0d requests, %0d responses over %0d threshold settings",
               requests_sent, results_checked, thr_settings);
      $display("accepted %0d, zero-sample %0d, saturated rate %0d, mismatches %0d",
               accepted_seen, zero_sample_seen, saturated_seen, mismatch_count);
      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// File: sim.f
hdl/erbe_pkg.sv
hdl/erbe_if.sv
hdl/erbe_front.sv
hdl/erbe_div.sv
hdl/erbe_entropy.sv
hdl/error_rate_binary_entropy_estimator_top.sv
tb/sv/tb_error_rate_binary_entropy_estimator_top.sv
